FILE: rtl/irpd_pkg.sv
// ----------------------------------------------------------------------------
// irpd_pkg
// Shared types, codes and pulse-width thresholds for the IR pulse decoder.
// ----------------------------------------------------------------------------
package irpd_pkg;

    localparam int FRAME_BITS = 32;
    localparam int BIT_IDX_W  = $clog2(FRAME_BITS);

    localparam logic [1:0] OP_LOW  = 2'd0;
    localparam logic [1:0] OP_HIGH = 2'd1;
    localparam logic [1:0] OP_PAIR = 2'd2;
    localparam logic [1:0] OP_TICK = 2'd3;

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_DATA  = 2'd1;
    localparam logic [1:0] PH_END   = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_TIMEOUT  = 3'd1;
    localparam logic [2:0] ST_BAD_START = 3'd2;
    localparam logic [2:0] ST_BAD_BIT  = 3'd3;
    localparam logic [2:0] ST_MISMATCH = 3'd4;
    localparam logic [2:0] ST_BAD_END  = 3'd5;

    localparam logic [15:0] START_LOW_MIN  = 16'd4000;
    localparam logic [15:0] START_LOW_MAX  = 16'd15000;
    localparam logic [15:0] SYNC_HIGH_MAX  = 16'd6000;
    localparam logic [15:0] SYNC_HIGH_MIN  = 16'd1500;
    localparam logic [15:0] LONG_HIGH_MIN  = 16'd4000;
    localparam logic [15:0] MARK_MIN       = 16'd400;
    localparam logic [15:0] MARK_MAX       = 16'd700;
    localparam logic [15:0] REPEAT_LOW_MAX = 16'd800;
    localparam logic [15:0] ONE_HIGH_MIN   = 16'd1200;
    localparam logic [15:0] ONE_HIGH_MAX   = 16'd2500;

    localparam logic [3:0]  SYNC_DISCARD_MAX = 4'd10;
    localparam logic [15:0] TIMEOUT_RESET    = 16'd200;
    localparam logic [15:0] ERR_CUSTOM       = 16'hFFFF;
    localparam logic [7:0]  ERR_DATA         = 8'hFF;

    typedef struct packed {
        logic [1:0]            phase;
        logic                  awaits_high;
        logic [3:0]            sync_discards;
        logic [BIT_IDX_W-1:0]  bit_index;
        logic [FRAME_BITS-1:0] frame_bits;
        logic [2:0]            last_status;
        logic [15:0]           last_custom;
        logic [7:0]            last_data;
        logic                  timer_running;
        logic [15:0]           timer_count;
    } irpd_state_t;

    typedef struct packed {
        logic        valid;
        logic [2:0]  status;
        logic [15:0] custom_code;
        logic [7:0]  data_code;
    } irpd_result_t;

endpackage

FILE: rtl/irpd_step.sv
// ----------------------------------------------------------------------------
// irpd_step
// Next-state and result logic for one decoder item (pulse, pair or tick).
// ----------------------------------------------------------------------------
module irpd_step (
    input  irpd_pkg::irpd_state_t  state_i,
    input  logic [1:0]             op,
    input  logic [15:0]            low_width,
    input  logic [15:0]            high_width,
    input  logic [15:0]            timeout_ticks,
    output irpd_pkg::irpd_state_t  state_o,
    output irpd_pkg::irpd_result_t res_o
);
    import irpd_pkg::*;

    logic                 low_mark;
    logic                 high_zero;
    logic                 high_one;
    logic                 long_high;
    logic [15:0]          count_inc;
    logic [7:0]           byte2;
    logic [7:0]           byte3;

    assign low_mark  = (low_width > MARK_MIN) && (low_width < MARK_MAX);
    assign high_zero = (high_width > MARK_MIN) && (high_width < MARK_MAX);
    assign high_one  = (high_width > ONE_HIGH_MIN) && (high_width < ONE_HIGH_MAX);
    assign long_high = high_width > LONG_HIGH_MIN;
    assign count_inc = state_i.timer_count + 16'd1;
    assign byte2     = state_i.frame_bits[23:16];
    assign byte3     = state_i.frame_bits[31:24];

    always_comb begin
        logic fail;
        logic [2:0] fail_code;
        logic do_high;
        state_o   = state_i;
        res_o     = '0;
        fail      = 1'b0;
        fail_code = ST_OK;
        do_high   = 1'b0;

        if (op == OP_TICK) begin
            if (state_i.timer_running) begin
                state_o.timer_count = count_inc;
                if ((count_inc >= timeout_ticks) || (count_inc == 16'd0)) begin
                    state_o.timer_count = 16'd0;
                    fail      = 1'b1;
                    fail_code = ST_TIMEOUT;
                end
            end
        end else if (state_i.phase == PH_DATA) begin
            if (op == OP_PAIR) begin
                if ((state_i.bit_index == '0) && long_high) begin
                    if ((low_width > MARK_MIN) && (low_width < REPEAT_LOW_MAX)) begin
                        // repeat mark: re-emit last result
                        state_o.phase         = PH_START;
                        state_o.awaits_high   = 1'b0;
                        state_o.bit_index     = '0;
                        state_o.timer_running = 1'b0;
                        res_o.valid       = 1'b1;
                        res_o.status      = state_i.last_status;
                        res_o.custom_code = state_i.last_custom;
                        res_o.data_code   = state_i.last_data;
                    end else begin
                        fail      = 1'b1;
                        fail_code = ST_BAD_BIT;
                    end
                end else if (low_mark && (high_zero || high_one)) begin
                    if (high_one) begin
                        state_o.frame_bits = state_i.frame_bits
                                           | (FRAME_BITS'(1) << state_i.bit_index);
                    end
                    if (state_i.bit_index == BIT_IDX_W'(FRAME_BITS - 1)) begin
                        state_o.bit_index = '0;
                        state_o.phase     = PH_END;
                    end else begin
                        state_o.bit_index = state_i.bit_index + BIT_IDX_W'(1);
                    end
                end else begin
                    fail      = 1'b1;
                    fail_code = ST_BAD_BIT;
                end
            end
        end else if (state_i.phase == PH_END) begin
            if (op == OP_PAIR) begin
                if (!(low_mark && long_high)) begin
                    fail      = 1'b1;
                    fail_code = ST_BAD_END;
                end else if ((byte2 ^ byte3) != 8'hFF) begin
                    fail      = 1'b1;
                    fail_code = ST_MISMATCH;
                end else begin
                    state_o.phase         = PH_START;
                    state_o.awaits_high   = 1'b0;
                    state_o.bit_index     = '0;
                    state_o.timer_running = 1'b0;
                    state_o.last_status   = ST_OK;
                    state_o.last_custom   = state_i.frame_bits[15:0];
                    state_o.last_data     = byte2;
                    res_o.valid       = 1'b1;
                    res_o.status      = ST_OK;
                    res_o.custom_code = state_i.frame_bits[15:0];
                    res_o.data_code   = byte2;
                end
            end
        end else begin
            state_o.phase = PH_START;
            if (!state_i.awaits_high) begin
                if (op != OP_HIGH) begin
                    if (!((low_width > START_LOW_MIN) && (low_width < START_LOW_MAX))) begin
                        fail      = 1'b1;
                        fail_code = ST_BAD_START;
                    end else begin
                        state_o.awaits_high   = 1'b1;
                        state_o.sync_discards = 4'd0;
                        state_o.timer_running = 1'b1;
                        state_o.timer_count   = 16'd0;
                        do_high = (op == OP_PAIR);
                    end
                end
            end else begin
                do_high = (op != OP_LOW);
            end

            if (do_high) begin
                if (state_o.sync_discards < SYNC_DISCARD_MAX) begin
                    if (high_width > SYNC_HIGH_MAX) begin
                        state_o.sync_discards = state_o.sync_discards + 4'd1;
                    end else if (high_width > SYNC_HIGH_MIN) begin
                        state_o.phase       = PH_DATA;
                        state_o.awaits_high = 1'b0;
                        state_o.bit_index   = '0;
                        state_o.frame_bits  = '0;
                    end else begin
                        fail      = 1'b1;
                        fail_code = ST_BAD_START;
                    end
                end else if ((high_width > SYNC_HIGH_MIN) && (high_width < SYNC_HIGH_MAX)) begin
                    state_o.phase       = PH_DATA;
                    state_o.awaits_high = 1'b0;
                    state_o.bit_index   = '0;
                    state_o.frame_bits  = '0;
                end else begin
                    fail      = 1'b1;
                    fail_code = ST_BAD_START;
                end
            end
        end

        if (fail) begin
            state_o.phase         = PH_START;
            state_o.awaits_high   = 1'b0;
            state_o.bit_index     = '0;
            state_o.timer_running = 1'b0;
            state_o.last_status   = fail_code;
            state_o.last_custom   = ERR_CUSTOM;
            state_o.last_data     = ERR_DATA;
            res_o.valid       = 1'b1;
            res_o.status      = fail_code;
            res_o.custom_code = ERR_CUSTOM;
            res_o.data_code   = ERR_DATA;
        end
    end

endmodule

FILE: rtl/ir_remote_pulse_decoder.sv
// ----------------------------------------------------------------------------
// ir_remote_pulse_decoder
// NEC style IR frame decoder driven by measured pulse widths and timer ticks.
//
// Input channel s_*: one item per accepted handshake, op selects a low pulse,
// a high pulse, a low+high pair or a timer tick; widths are in microseconds.
// Result channel m_*: status, 16-bit custom code and 8-bit data code. An item
// yields zero or one result.
// cfg_wr_en / cfg_wr_data: frame timeout in ticks.
// An accepted item is held in the input register and decoded from there; its
// result (if any) is written to the result register that drives m_*.
// Throughput: one item per cycle while the result register is empty or taken;
// the decode is a single pass of logic between the input register and the
// result register. When the result register holds an untaken result, the
// input register still takes one more item; further items wait until m_ready.
// Reset (aresetn low, synchronous): frame state back to start, timer off,
// last result cleared to status ok with all-ones codes, timeout = 200.
// ----------------------------------------------------------------------------
module ir_remote_pulse_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [15:0] s_low_width,
    input  logic [15:0] s_high_width,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [15:0] m_custom_code,
    output logic [7:0]  m_data_code
);
    import irpd_pkg::*;

    logic         in_valid_reg;
    logic [1:0]   in_op_reg;
    logic [15:0]  in_low_reg;
    logic [15:0]  in_high_reg;
    logic [15:0]  timeout_reg;
    irpd_state_t  state_reg;
    irpd_state_t  state_next;
    irpd_result_t res_next;
    logic         out_valid_reg;
    logic [2:0]   out_status_reg;
    logic [15:0]  out_custom_reg;
    logic [7:0]   out_data_reg;
    logic         advance;

    irpd_step u_step (
        .state_i       (state_reg),
        .op            (in_op_reg),
        .low_width     (in_low_reg),
        .high_width    (in_high_reg),
        .timeout_ticks (timeout_reg),
        .state_o       (state_next),
        .res_o         (res_next)
    );

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            timeout_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg   <= s_op;
            in_low_reg  <= s_low_width;
            in_high_reg <= s_high_width;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase         <= PH_START;
            state_reg.awaits_high   <= 1'b0;
            state_reg.sync_discards <= 4'd0;
            state_reg.bit_index     <= '0;
            state_reg.frame_bits    <= '0;
            state_reg.last_status   <= ST_OK;
            state_reg.last_custom   <= ERR_CUSTOM;
            state_reg.last_data     <= ERR_DATA;
            state_reg.timer_running <= 1'b0;
            state_reg.timer_count   <= 16'd0;
        end else if (in_valid_reg && advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_valid_reg && advance && res_next.valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid_reg && advance && res_next.valid) begin
            out_status_reg <= res_next.status;
            out_custom_reg <= res_next.custom_code;
            out_data_reg   <= res_next.data_code;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_status      = out_status_reg;
    assign m_custom_code = out_custom_reg;
    assign m_data_code   = out_data_reg;

endmodule

FILE: bench/tb_ir_remote_pulse_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ir_remote_pulse_decoder
// Self-checking bench for the NEC style IR pulse decoder. A short table of
// directed items covers width limits, repeat marks, ignored pulses and the
// timeout, bad start and bad bit statuses. Random phases follow: frames with
// random content, repeat marks and noise, under several frame timeouts. Results
// are scored in order against a behavioral decoder kept inside the bench.
// ----------------------------------------------------------------------------
module tb_ir_remote_pulse_decoder;
    import irpd_pkg::*;

    localparam int RANDOM_ITEMS = 1125;
    localparam int N_PHASES     = 6;
    localparam int HOLD_CYCLES  = 400;
    localparam int EXP_DEPTH    = 64;

    typedef enum logic [1:0] {PREDICTED, KNOWN, SET_TIMEOUT} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  op;
        logic [15:0] lw;
        logic [15:0] hw;
        logic [2:0]  st;
    } stim_row_t;

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        cfg_wr_en    = 1'b0;
    logic [15:0] cfg_wr_data  = 16'd0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [1:0]  s_op         = OP_LOW;
    logic [15:0] s_low_width  = 16'd0;
    logic [15:0] s_high_width = 16'd0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [2:0]  m_status;
    logic [15:0] m_custom_code;
    logic [7:0]  m_data_code;

    // decoder model state
    logic [1:0]   phase;
    logic         awaits_high;
    int           discards;
    logic [4:0]   bit_idx;
    logic [31:0]  frame_word;
    irpd_result_t last_result;
    logic         timer_on;
    logic [15:0]  timer_cnt;
    logic [15:0]  timeout_ticks;
    logic         pulse_ignored;

    irpd_result_t exp_fifo[EXP_DEPTH];
    int exp_wr        = 0;
    int exp_rd        = 0;
    int idle_pct      = 26;
    int tick_pct      = 5;
    int hold_asked    = 0;
    int hold_given    = 0;
    int hold_left     = 0;
    int items_sent    = 0;
    int items_counted = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int n_settings    = 0;
    int status_hist[8];

    int thresholds[12] = '{0, 400, 700, 800, 1000, 1200, 1500, 2500, 4000, 6000,
                           15000, 65535};

    stim_row_t directed_rows[28] = '{
        '{PREDICTED,   OP_PAIR, 16'd9000,  16'd4500,  ST_OK},
        '{KNOWN,       OP_PAIR, 16'd560,   16'd5000,  ST_OK},
        '{PREDICTED,   OP_HIGH, 16'd0,     16'd65535, ST_OK},
        '{KNOWN,       OP_LOW,  16'd0,     16'd0,     ST_BAD_START},
        '{KNOWN,       OP_PAIR, 16'd65535, 16'd65535, ST_BAD_START},
        '{PREDICTED,   OP_TICK, 16'd65535, 16'd65535, ST_OK},
        '{PREDICTED,   OP_LOW,  16'd4001,  16'd0,     ST_OK},
        '{PREDICTED,   OP_LOW,  16'd0,     16'd0,     ST_OK},
        '{PREDICTED,   OP_HIGH, 16'd0,     16'd65535, ST_OK},
        '{KNOWN,       OP_HIGH, 16'd0,     16'd1500,  ST_BAD_START},
        '{PREDICTED,   OP_PAIR, 16'd14999, 16'd1501,  ST_OK},
        '{PREDICTED,   OP_HIGH, 16'd0,     16'd0,     ST_OK},
        '{KNOWN,       OP_PAIR, 16'd401,   16'd4001,  ST_BAD_START},
        '{KNOWN,       OP_PAIR, 16'd4000,  16'd4500,  ST_BAD_START},
        '{KNOWN,       OP_PAIR, 16'd15000, 16'd4500,  ST_BAD_START},
        '{PREDICTED,   OP_PAIR, 16'd9000,  16'd6000,  ST_OK},
        '{KNOWN,       OP_PAIR, 16'd560,   16'd3000,  ST_BAD_BIT},
        '{PREDICTED,   OP_PAIR, 16'd9000,  16'd2250,  ST_OK},
        '{KNOWN,       OP_PAIR, 16'd799,   16'd65535, ST_BAD_BIT},
        '{PREDICTED,   OP_PAIR, 16'd9000,  16'd4500,  ST_OK},
        '{PREDICTED,   OP_PAIR, 16'd699,   16'd699,   ST_OK},
        '{PREDICTED,   OP_PAIR, 16'd401,   16'd2499,  ST_OK},
        '{KNOWN,       OP_PAIR, 16'd560,   16'd0,     ST_BAD_BIT},
        '{SET_TIMEOUT, OP_TICK, 16'd0,     16'd1,     ST_OK},
        '{PREDICTED,   OP_PAIR, 16'd9000,  16'd4500,  ST_OK},
        '{KNOWN,       OP_TICK, 16'd0,     16'd0,     ST_TIMEOUT},
        '{PREDICTED,   OP_TICK, 16'd0,     16'd0,     ST_OK},
        '{SET_TIMEOUT, OP_TICK, 16'd0,     16'd65535, ST_OK}
    };

    ir_remote_pulse_decoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_low_width   (s_low_width),
        .s_high_width  (s_high_width),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_custom_code (m_custom_code),
        .m_data_code   (m_data_code)
    );

    always #1 aclk = ~aclk;

    function automatic void reset_decoder();
        phase         = PH_START;
        awaits_high   = 1'b0;
        discards      = 0;
        bit_idx       = 5'd0;
        frame_word    = 32'd0;
        last_result   = '{1'b1, ST_OK, 16'hFFFF, 8'hFF};
        timer_on      = 1'b0;
        timer_cnt     = 16'd0;
        timeout_ticks = 16'd200;
    endfunction

    function automatic void go_start();
        phase       = PH_START;
        awaits_high = 1'b0;
        bit_idx     = 5'd0;
        timer_on    = 1'b0;
    endfunction

    function automatic irpd_result_t frame_error(input logic [2:0] st);
        go_start();
        last_result = '{1'b1, st, 16'hFFFF, 8'hFF};
        return last_result;
    endfunction

    function automatic void open_data();
        phase       = PH_DATA;
        awaits_high = 1'b0;
        bit_idx     = 5'd0;
        frame_word  = 32'd0;
    endfunction

    function automatic irpd_result_t decode_item(input logic [1:0] op,
                                                 input logic [15:0] lw,
                                                 input logic [15:0] hw);
        irpd_result_t r;
        logic         one;
        r = '0;
        pulse_ignored = 1'b0;

        if (op == OP_TICK) begin
            if (!timer_on) begin
                pulse_ignored = 1'b1;
                return r;
            end
            timer_cnt = timer_cnt + 16'd1;
            if (timer_cnt >= timeout_ticks || timer_cnt == 16'd0) begin
                timer_cnt = 16'd0;
                r = frame_error(ST_TIMEOUT);
            end
            return r;
        end

        if (phase == PH_DATA) begin
            if (op != OP_PAIR) begin
                pulse_ignored = 1'b1;
                return r;
            end
            // repeat mark sits where the first data bit would be
            if (bit_idx == 5'd0 && hw > 4000) begin
                if (lw > 400 && lw < 800) begin
                    go_start();
                    return last_result;
                end
                return frame_error(ST_BAD_BIT);
            end
            if (!(lw > 400 && lw < 700))
                return frame_error(ST_BAD_BIT);
            if (hw > 400 && hw < 700)
                one = 1'b0;
            else if (hw > 1200 && hw < 2500)
                one = 1'b1;
            else
                return frame_error(ST_BAD_BIT);
            frame_word[bit_idx] = one;
            if (bit_idx == 5'd31) begin
                bit_idx = 5'd0;
                phase   = PH_END;
            end else begin
                bit_idx = bit_idx + 5'd1;
            end
            return r;
        end

        if (phase == PH_END) begin
            if (op != OP_PAIR) begin
                pulse_ignored = 1'b1;
                return r;
            end
            if (!(lw > 400 && lw < 700 && hw > 4000))
                return frame_error(ST_BAD_END);
            if ((frame_word[23:16] ^ frame_word[31:24]) != 8'hFF)
                return frame_error(ST_MISMATCH);
            go_start();
            last_result = '{1'b1, ST_OK, frame_word[15:0], frame_word[23:16]};
            return last_result;
        end

        phase = PH_START;
        if (!awaits_high) begin
            if (op == OP_HIGH) begin
                pulse_ignored = 1'b1;
                return r;
            end
            if (!(lw > 4000 && lw < 15000))
                return frame_error(ST_BAD_START);
            awaits_high = 1'b1;
            discards    = 0;
            timer_on    = 1'b1;
            timer_cnt   = 16'd0;
            if (op == OP_LOW)
                return r;
        end else if (op == OP_LOW) begin
            pulse_ignored = 1'b1;
            return r;
        end

        if (discards < 10) begin
            if (hw > 6000) begin
                discards++;
                return r;
            end
            if (hw > 1500) begin
                open_data();
                return r;
            end
            return frame_error(ST_BAD_START);
        end
        if (hw > 1500 && hw < 6000) begin
            open_data();
            return r;
        end
        return frame_error(ST_BAD_START);
    endfunction

    function automatic logic [15:0] any_width();
        logic [15:0] v;
        case ($urandom_range(0, 3))
            0:       v = 16'($urandom);
            1:       v = 16'(thresholds[$urandom_range(0, 11)] + $urandom_range(0, 2) - 1);
            default: v = 16'($urandom_range(0, 16000));
        endcase
        return v;
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [15:0] lw,
                             input logic [15:0] hw, input bit known = 1'b0,
                             input logic [2:0] known_st = ST_OK);
        irpd_result_t r;
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_op         <= op;
        s_low_width  <= lw;
        s_high_width <= hw;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        r = decode_item(op, lw, hw);
        if (known)
            r = '{1'b1, known_st, 16'hFFFF, 8'hFF};
        if (r.valid) begin
            exp_fifo[exp_wr % EXP_DEPTH] = r;
            exp_wr++;
        end
        items_sent++;
        if (!pulse_ignored)
            items_counted++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (exp_wr != exp_rd)
            @(posedge aclk);
        // let an item that yields nothing clear the pipeline
        repeat (6) @(posedge aclk);
    endtask

    task automatic set_timeout(input logic [15:0] ticks);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ticks;
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        timeout_ticks = ticks;
        n_settings++;
    endtask

    task automatic send_frame();
        logic [31:0] word;
        logic [15:0] sync_hw;
        int          n_disc;
        int          flaw;
        int          flaw_pos;
        word = $urandom;
        if ($urandom_range(0, 9) < 7)
            word[31:24] = ~word[23:16];
        flaw     = $urandom_range(0, 99);
        flaw_pos = $urandom_range(0, 31);
        n_disc   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
        sync_hw  = (n_disc >= 10 && $urandom_range(0, 3) == 0)
                   ? 16'd6000 : 16'($urandom_range(1501, 5999));

        if (n_disc == 0 && $urandom_range(0, 1)) begin
            send_item(OP_PAIR, 16'($urandom_range(4001, 14999)), sync_hw);
        end else begin
            send_item(OP_LOW, 16'($urandom_range(4001, 14999)), any_width());
            if ($urandom_range(0, 4) == 0)
                send_item(OP_LOW, any_width(), any_width());
            repeat (n_disc)
                send_item($urandom_range(0, 1) ? OP_HIGH : OP_PAIR, any_width(),
                          16'($urandom_range(6001, 65535)));
            send_item($urandom_range(0, 1) ? OP_HIGH : OP_PAIR, any_width(), sync_hw);
        end

        for (int i = 0; i < 32; i++) begin
            if ($urandom_range(0, 99) < tick_pct)
                send_item(OP_TICK, 16'($urandom), 16'($urandom));
            if ($urandom_range(0, 99) < 3)
                send_item($urandom_range(0, 1) ? OP_HIGH : OP_LOW, any_width(), any_width());
            if (flaw < 8 && i == flaw_pos)
                send_item(OP_PAIR, any_width(), any_width());
            else
                send_item(OP_PAIR, 16'($urandom_range(401, 699)),
                          word[i] ? 16'($urandom_range(1201, 2499))
                                  : 16'($urandom_range(401, 699)));
        end

        if (flaw >= 8 && flaw < 14)
            send_item(OP_PAIR, any_width(), any_width());
        else
            send_item(OP_PAIR, 16'($urandom_range(401, 699)),
                      16'($urandom_range(4001, 65535)));
    endtask

    // result side: ready pattern, long hold-off and scoring
    always @(posedge aclk) begin
        irpd_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            status_hist[m_status]++;
            if (exp_wr == exp_rd) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d custom %h data %h",
                             m_status, m_custom_code, m_data_code);
            end else begin
                want = exp_fifo[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (m_status !== want.status || m_custom_code !== want.custom_code ||
                    m_data_code !== want.data_code) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected %0d %h %h, got %0d %h %h",
                                 results_seen, want.status, want.custom_code,
                                 want.data_code, m_status, m_custom_code, m_data_code);
                end
            end
        end
        if (hold_given < hold_asked) begin
            hold_given++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= (idle_pct == 0) || ($urandom_range(0, 99) >= idle_pct);
        end
    end

    initial begin
        #1_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int base;
        int goal;
        int pick;
        reset_decoder();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            case (directed_rows[i].kind)
                SET_TIMEOUT: begin
                    wait_drained();
                    set_timeout(directed_rows[i].hw);
                end
                KNOWN: send_item(directed_rows[i].op, directed_rows[i].lw,
                                 directed_rows[i].hw, 1'b1, directed_rows[i].st);
                default: send_item(directed_rows[i].op, directed_rows[i].lw,
                                   directed_rows[i].hw);
            endcase
        end

        base = items_sent;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_drained();
            case (ph)
                0:       set_timeout(16'd200);
                1:       set_timeout(16'd1);
                2:       set_timeout(16'd65535);
                3:       set_timeout(16'($urandom_range(2, 12)));
                4:       set_timeout(16'($urandom_range(13, 60)));
                default: set_timeout(16'($urandom_range(1, 65535)));
            endcase
            idle_pct = (ph == 2) ? 0 : 26;
            tick_pct = (ph == 1) ? 1 : 5;
            if (ph == 1)
                hold_asked++;
            goal = base + (ph + 1) * RANDOM_ITEMS / N_PHASES;
            while (items_sent < goal) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    send_frame();
                end else if (pick < 65) begin
                    send_item(OP_PAIR, 16'($urandom_range(4001, 14999)),
                              16'($urandom_range(1501, 5999)));
                    send_item(OP_PAIR, 16'($urandom_range(350, 850)),
                              16'($urandom_range(3900, 65535)));
                end else begin
                    repeat ($urandom_range(1, 6))
                        send_item(2'($urandom_range(0, 3)), any_width(), any_width());
                end
            end
        end

        wait_drained();
        repeat (10) @(posedge aclk);

        $display("Sent %0d items (%0d decoded) under %0d timeout settings, %0d results.",
                 items_sent, items_counted, n_settings, results_seen);
        $display({"Status mix: ok %0d, timeout %0d, bad start %0d, ",
                  "bad bit %0d, mismatch %0d, bad end %0d"},
                 status_hist[ST_OK], status_hist[ST_TIMEOUT], status_hist[ST_BAD_START],
                 status_hist[ST_BAD_BIT], status_hist[ST_MISMATCH], status_hist[ST_BAD_END]);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
